FILE: design/assert_macros.svh
// assertion helpers used by swm_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every aclk edge outside reset
`define SWM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// plain invariant that holds on every edge outside reset
`define SWM_ASSERT_ALWAYS(label, cond, msg) \
    `SWM_ASSERT(label, (cond), msg)

`endif

FILE: design/swm_pkg.sv
package swm_pkg;

    // build-time sizes
    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 32;
    localparam int CFG_W       = 7;
    localparam int ADDR_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W       = $clog2(MAX_WINDOW + 1);

    // write data select for the sorted store
    localparam logic WSEL_RDATA = 1'b0;
    localparam logic WSEL_KEY   = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic              cap_key;
        logic              ring_we;
        logic [ADDR_W-1:0] ring_waddr;
        logic [ADDR_W-1:0] ring_raddr;
        logic              cap_old;
        logic [ADDR_W-1:0] sort_raddr;
        logic              sort_we;
        logic [ADDR_W-1:0] sort_waddr;
        logic              sort_wsel;
        logic              load_med;
    } cmd_t;

    // compare results back to the controller
    typedef struct packed {
        logic eq_old;
        logic gt_key;
    } status_t;

endpackage

FILE: design/sliding_window_median.sv
// Sliding-window lower-median filter on signed 32-bit samples. Each request
// carries a sample in s_tdata and a start flag in s_tuser that empties the
// window first. The last window_size samples (1..64, 0 acts as 1, larger as
// 64) are kept in an arrival ring and in a sorted store, both RAMs with one
// write and one read port; once the window is full every request returns
// element (k-1)/2 of the ascending window on m_tdata, while it fills nothing
// is returned. Writing cfg_wdata with cfg_we also empties the window; write
// it only while idle. One request at a time: with a full window a request
// takes a ring read, a pass over the sorted store to drop the oldest sample,
// a downward pass to insert the new one and a median read; while filling the
// ring read and the removal pass are skipped. The sorted store port walks
// one entry per cycle. A finished median waits in an output register while
// the next request is taken. No clearing pass after reset.
module sliding_window_median (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [swm_pkg::SAMPLE_BITS-1:0] s_tdata,   // [31:0] sample
    input  logic                            s_tuser,   // [0] start_req
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [swm_pkg::SAMPLE_BITS-1:0] m_tdata,   // [31:0] median
    input  logic                            cfg_we,
    input  logic [swm_pkg::CFG_W-1:0]       cfg_wdata
);

    swm_pkg::cmd_t    cmd;
    swm_pkg::status_t sts;

    // sequencer and counters
    swm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tuser   (s_tuser),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

    // sample stores and compares
    swm_dp u_dp (
        .aclk    (aclk),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .sts     (sts),
        .m_tdata (m_tdata)
    );

endmodule

FILE: design/swm_ram.sv
module swm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read of the old contents
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/swm_ctrl.sv
`include "assert_macros.svh"

module swm_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tuser,
    output logic                        s_tready,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic                        cfg_we,
    input  logic [swm_pkg::CFG_W-1:0]   cfg_wdata,
    output swm_pkg::cmd_t               cmd,
    input  swm_pkg::status_t            sts
);

    localparam int ADDR_W = swm_pkg::ADDR_W;
    localparam int CNT_W  = swm_pkg::CNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OLD,
        ST_REMOVE,
        ST_INS_START,
        ST_INSERT,
        ST_INS_LAST,
        ST_FINISH,
        ST_MED
    } state_t;

    state_t                     state_reg, state_next;
    logic [swm_pkg::CFG_W-1:0]  ws_reg, ws_next;
    logic [CNT_W-1:0]           fill_reg, fill_next;
    logic [ADDR_W-1:0]          ptr_reg, ptr_next;
    logic [CNT_W-1:0]           idx_reg, idx_next;
    logic                       found_reg, found_next;
    logic                       m_valid_reg, m_valid_next;

    logic [CNT_W-1:0]           k_eff;
    logic [CNT_W-1:0]           ptr_ext;
    logic [CNT_W-1:0]           fill_eff;
    logic [ADDR_W-1:0]          ptr_eff;
    logic [ADDR_W-1:0]          mid_addr;
    logic                       accept;

    // effective window length, clamped to 1..MAX_WINDOW
    always_comb begin
        if (ws_reg == '0) begin
            k_eff = CNT_W'(1);
        end else if (int'(ws_reg) > swm_pkg::MAX_WINDOW) begin
            k_eff = CNT_W'(swm_pkg::MAX_WINDOW);
        end else begin
            k_eff = CNT_W'(ws_reg);
        end
    end

    assign ptr_ext  = CNT_W'(ptr_reg);
    assign accept   = s_tvalid && (state_reg == ST_IDLE);
    assign fill_eff = s_tuser ? '0 : fill_reg;
    assign ptr_eff  = (s_tuser || (ptr_ext >= k_eff)) ? '0 : ptr_reg;
    assign mid_addr = ADDR_W'((k_eff - CNT_W'(1)) >> 1);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    // sequencer: remove the oldest sample, insert the new one, read the median
    always_comb begin
        state_next   = state_reg;
        ws_next      = ws_reg;
        fill_next    = fill_reg;
        ptr_next     = ptr_reg;
        idx_next     = idx_reg;
        found_next   = found_reg;
        m_valid_next = m_valid_reg && !m_tready;

        cmd            = '0;
        cmd.ring_raddr = ptr_eff;
        cmd.ring_waddr = ptr_eff;
        cmd.sort_wsel  = swm_pkg::WSEL_KEY;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.cap_key = 1'b1;
                    cmd.ring_we = 1'b1;
                    fill_next   = fill_eff;
                    ptr_next    = ptr_eff;
                    if (fill_eff == k_eff) begin
                        state_next = ST_OLD;
                    end else begin
                        state_next = ST_INS_START;
                    end
                end
            end
            ST_OLD: begin
                cmd.cap_old    = 1'b1;
                cmd.sort_raddr = '0;
                idx_next       = '0;
                found_next     = 1'b0;
                state_next     = ST_REMOVE;
            end
            ST_REMOVE: begin
                // close the gap left by one copy of the oldest sample
                cmd.sort_raddr = ADDR_W'(idx_reg + CNT_W'(1));
                if (found_reg) begin
                    cmd.sort_we    = 1'b1;
                    cmd.sort_waddr = ADDR_W'(idx_reg - CNT_W'(1));
                    cmd.sort_wsel  = swm_pkg::WSEL_RDATA;
                end else if (sts.eq_old) begin
                    found_next = 1'b1;
                end
                if (idx_reg == fill_reg - CNT_W'(1)) begin
                    if (found_reg || sts.eq_old) begin
                        fill_next = fill_reg - CNT_W'(1);
                    end
                    state_next = ST_INS_START;
                end else begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_INS_START: begin
                if (fill_reg == '0) begin
                    cmd.sort_we    = 1'b1;
                    cmd.sort_waddr = '0;
                    state_next     = ST_FINISH;
                end else begin
                    cmd.sort_raddr = ADDR_W'(fill_reg - CNT_W'(1));
                    idx_next       = fill_reg - CNT_W'(1);
                    state_next     = ST_INSERT;
                end
            end
            ST_INSERT: begin
                // walk down, moving larger entries up by one
                cmd.sort_raddr = ADDR_W'(idx_reg - CNT_W'(1));
                cmd.sort_we    = 1'b1;
                cmd.sort_waddr = ADDR_W'(idx_reg + CNT_W'(1));
                if (sts.gt_key) begin
                    cmd.sort_wsel = swm_pkg::WSEL_RDATA;
                    if (idx_reg == '0) begin
                        state_next = ST_INS_LAST;
                    end else begin
                        idx_next = idx_reg - CNT_W'(1);
                    end
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_INS_LAST: begin
                cmd.sort_we    = 1'b1;
                cmd.sort_waddr = '0;
                state_next     = ST_FINISH;
            end
            ST_FINISH: begin
                fill_next      = fill_reg + CNT_W'(1);
                ptr_next       = (ptr_ext + CNT_W'(1) >= k_eff) ? '0
                                                               : ptr_reg + ADDR_W'(1);
                cmd.sort_raddr = mid_addr;
                if (fill_reg + CNT_W'(1) == k_eff) begin
                    state_next = ST_MED;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_MED: begin
                // wait for the output register to free up
                cmd.sort_raddr = mid_addr;
                if (!m_valid_reg || m_tready) begin
                    cmd.load_med = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // window length write empties the window
        if (cfg_we) begin
            ws_next   = cfg_wdata;
            fill_next = '0;
            ptr_next  = '0;
        end
    end

    // state and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ws_reg      <= swm_pkg::CFG_W'(swm_pkg::MAX_WINDOW);
            fill_reg    <= '0;
            ptr_reg     <= '0;
            idx_reg     <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ws_reg      <= ws_next;
            fill_reg    <= fill_next;
            ptr_reg     <= ptr_next;
            idx_reg     <= idx_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `SWM_ASSERT_ALWAYS(a_fill_in_window, fill_reg <= k_eff, "fill count beyond window")
    `SWM_ASSERT_ALWAYS(a_ptr_in_window, ptr_ext < k_eff, "ring pointer beyond window")
    `SWM_ASSERT(a_remove_when_full, (state_reg == ST_REMOVE) |-> (fill_reg == k_eff),
                "removal on partial window")
    `SWM_ASSERT(a_median_when_full, (state_reg == ST_MED) |-> (fill_reg == k_eff),
                "median read on partial window")

endmodule

FILE: design/swm_dp.sv
module swm_dp (
    input  logic                            aclk,
    input  logic [swm_pkg::SAMPLE_BITS-1:0] s_tdata,
    input  swm_pkg::cmd_t                   cmd,
    output swm_pkg::status_t                sts,
    output logic [swm_pkg::SAMPLE_BITS-1:0] m_tdata
);

    localparam int W = swm_pkg::SAMPLE_BITS;

    logic [W-1:0] key_reg;
    logic [W-1:0] old_reg;
    logic [W-1:0] med_reg;
    logic [W-1:0] ring_rdata;
    logic [W-1:0] sort_rdata;
    logic [W-1:0] sort_wdata;

    // samples in arrival order
    swm_ram #(
        .WIDTH(W),
        .DEPTH(swm_pkg::MAX_WINDOW)
    ) u_ring (
        .aclk  (aclk),
        .we    (cmd.ring_we),
        .waddr (cmd.ring_waddr),
        .wdata (s_tdata),
        .raddr (cmd.ring_raddr),
        .rdata (ring_rdata)
    );

    // samples in ascending order
    assign sort_wdata = (cmd.sort_wsel == swm_pkg::WSEL_KEY) ? key_reg : sort_rdata;

    swm_ram #(
        .WIDTH(W),
        .DEPTH(swm_pkg::MAX_WINDOW)
    ) u_sorted (
        .aclk  (aclk),
        .we    (cmd.sort_we),
        .waddr (cmd.sort_waddr),
        .wdata (sort_wdata),
        .raddr (cmd.sort_raddr),
        .rdata (sort_rdata)
    );

    // compares against the leaving sample and the new sample
    assign sts.eq_old = (sort_rdata == old_reg);
    assign sts.gt_key = ($signed(sort_rdata) > $signed(key_reg));

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.cap_key) begin
            key_reg <= s_tdata;
        end
        if (cmd.cap_old) begin
            old_reg <= ring_rdata;
        end
        if (cmd.load_med) begin
            med_reg <= sort_rdata;
        end
    end

    assign m_tdata = med_reg;

endmodule
